### src/pca_pkg.sv
package pca_pkg;

    localparam int WordBits  = 64;
    localparam int DivStages = 64;
    localparam int ShiftMask = 63;
    localparam int WordBytes = 8;

    typedef enum logic [4:0] {
        OP_COPY     = 5'd0,
        OP_ADD      = 5'd1,
        OP_SUB      = 5'd2,
        OP_MUL      = 5'd3,
        OP_DIV      = 5'd4,
        OP_SDIV     = 5'd5,
        OP_REM      = 5'd6,
        OP_SREM     = 5'd7,
        OP_AND      = 5'd8,
        OP_OR       = 5'd9,
        OP_XOR      = 5'd10,
        OP_SHL      = 5'd11,
        OP_SHR      = 5'd12,
        OP_SAR      = 5'd13,
        OP_NEG      = 5'd14,
        OP_NOT      = 5'd15,
        OP_EQ       = 5'd16,
        OP_NE       = 5'd17,
        OP_LT       = 5'd18,
        OP_LE       = 5'd19,
        OP_SLT      = 5'd20,
        OP_SLE      = 5'd21,
        OP_ZEXT     = 5'd22,
        OP_SEXT     = 5'd23,
        OP_SUBPIECE = 5'd24
    } op_t;

    typedef enum logic [1:0] {
        FAULT_NONE    = 2'd0,
        FAULT_DIV_ZRO = 2'd1,
        FAULT_REM_ZRO = 2'd2
    } fault_t;

    // Bookkeeping that travels alongside the divider.
    typedef struct packed {
        logic       valid;
        logic [4:0] kind;
        logic [3:0] rs;
        logic       neg_q;
        logic       neg_r;
        logic       zero;
    } meta_t;

    typedef struct packed {
        meta_t                meta;
        logic [WordBits-1:0]  a;
        logic [WordBits-1:0]  b;
        logic [WordBits-1:0]  xa;
        logic [WordBits-1:0]  xb;
        logic [WordBits-1:0]  dvd;
        logic [WordBits-1:0]  dsr;
    } dec_t;

    typedef struct packed {
        meta_t               meta;
        logic [WordBits-1:0] res;
    } alu_t;

    // Sizes outside 1..7 mean the full word.
    function automatic logic [WordBits-1:0] size_mask(input logic [3:0] size);
        logic [WordBits-1:0] m;
        case (size)
            4'd1:    m = 64'h0000_0000_0000_00ff;
            4'd2:    m = 64'h0000_0000_0000_ffff;
            4'd3:    m = 64'h0000_0000_00ff_ffff;
            4'd4:    m = 64'h0000_0000_ffff_ffff;
            4'd5:    m = 64'h0000_00ff_ffff_ffff;
            4'd6:    m = 64'h0000_ffff_ffff_ffff;
            4'd7:    m = 64'h00ff_ffff_ffff_ffff;
            default: m = '1;
        endcase
        return m;
    endfunction

    function automatic logic [WordBits-1:0] sign_ext(input logic [WordBits-1:0] v,
                                                     input logic [3:0] size);
        logic s;
        case (size)
            4'd1:    s = v[7];
            4'd2:    s = v[15];
            4'd3:    s = v[23];
            4'd4:    s = v[31];
            4'd5:    s = v[39];
            4'd6:    s = v[47];
            4'd7:    s = v[55];
            default: s = 1'b0;
        endcase
        return s ? (v | ~size_mask(size)) : v;
    endfunction

endpackage

### src/pcode_integer_alu.sv
// Integer p-code ALU. Each transaction carries one operation with its operand
// and result byte sizes and returns one result with a fault code. The block is a
// pipeline (one decode stage, a 64-stage radix-2 divider that every operation
// travels alongside, and one output stage) and accepts one transaction per cycle;
// the whole pipeline holds while the output is stalled.
module pcode_integer_alu
    import pca_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // kind[4:0], operand_a[68:5], size_a[72:69], operand_b[136:73],
    // size_b[140:137], result_size[144:141], zero fill above
    input  logic [151:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result[63:0], fault[65:64], zero fill above
    output logic [71:0]  m_tdata
);

    logic        en;
    dec_t        dec;
    alu_t        alu;
    logic [63:0] quot, rem;
    logic        m_valid_reg;
    logic [63:0] res_reg, res_next;
    logic [1:0]  fault_reg, fault_next;
    logic [63:0] v;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    pca_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_tvalid),
        .kind        (s_tdata[4:0]),
        .operand_a   (s_tdata[68:5]),
        .size_a      (s_tdata[72:69]),
        .operand_b   (s_tdata[136:73]),
        .size_b      (s_tdata[140:137]),
        .result_size (s_tdata[144:141]),
        .dec         (dec)
    );

    pca_div u_div (
        .aclk (aclk),
        .en   (en),
        .dvd  (dec.dvd),
        .dsr  (dec.dsr),
        .quot (quot),
        .rem  (rem)
    );

    pca_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .dec     (dec),
        .alu     (alu)
    );

    always_comb begin
        fault_next = FAULT_NONE;
        case (alu.meta.kind)
            OP_DIV, OP_SDIV: begin
                if (alu.meta.zero) begin
                    v          = '0;
                    fault_next = FAULT_DIV_ZRO;
                end else begin
                    v = alu.meta.neg_q ? (~quot + 64'd1) : quot;
                end
            end
            OP_REM, OP_SREM: begin
                if (alu.meta.zero) begin
                    v          = '0;
                    fault_next = FAULT_REM_ZRO;
                end else begin
                    v = alu.meta.neg_r ? (~rem + 64'd1) : rem;
                end
            end
            default: v = alu.res;
        endcase
        res_next = v & size_mask(alu.meta.rs);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= alu.meta.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg   <= res_next;
            fault_reg <= fault_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, fault_reg, res_reg};

`ifndef SYNTHESIS
    a_fault_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[65:64] != 2'd3))
        else $error("fault code out of range");

    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[65:64] != 2'd0) |-> (m_tdata[63:0] == 64'd0))
        else $error("faulting result is not zero");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while pipeline is stalled");
`endif

endmodule

### src/pca_decode.sv
module pca_decode
    import pca_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [4:0]  kind,
    input  logic [63:0] operand_a,
    input  logic [3:0]  size_a,
    input  logic [63:0] operand_b,
    input  logic [3:0]  size_b,
    input  logic [3:0]  result_size,
    output dec_t        dec
);

    dec_t dec_reg;
    dec_t dec_next;
    logic signed_op;

    always_comb begin
        dec_next.a  = operand_a & size_mask(size_a);
        dec_next.b  = operand_b & size_mask(size_b);
        dec_next.xa = sign_ext(dec_next.a, size_a);
        dec_next.xb = sign_ext(dec_next.b, size_b);
        signed_op   = (kind == OP_SDIV) || (kind == OP_SREM);
        if (signed_op) begin
            dec_next.dvd = dec_next.xa[63] ? (~dec_next.xa + 64'd1) : dec_next.xa;
            dec_next.dsr = dec_next.xb[63] ? (~dec_next.xb + 64'd1) : dec_next.xb;
        end else begin
            dec_next.dvd = dec_next.a;
            dec_next.dsr = dec_next.b;
        end
        dec_next.meta.valid = in_valid;
        dec_next.meta.kind  = kind;
        dec_next.meta.rs    = result_size;
        dec_next.meta.neg_q = signed_op && (dec_next.xa[63] != dec_next.xb[63]);
        dec_next.meta.neg_r = signed_op && dec_next.xa[63];
        dec_next.meta.zero  = (dec_next.b == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_reg.meta.valid <= 1'b0;
        end else if (en) begin
            dec_reg <= dec_next;
        end
    end

    assign dec = dec_reg;

endmodule

### src/pca_div.sv
module pca_div
    import pca_pkg::*;
(
    input  logic                aclk,
    input  logic                en,
    input  logic [WordBits-1:0] dvd,
    input  logic [WordBits-1:0] dsr,
    output logic [WordBits-1:0] quot,
    output logic [WordBits-1:0] rem
);

    // One quotient bit per stage; the dividend register fills with quotient bits.
    logic [WordBits-1:0] q_reg [DivStages];
    logic [WordBits-1:0] r_reg [DivStages];
    logic [WordBits-1:0] d_reg [DivStages];
    logic [WordBits-1:0] q_next [DivStages];
    logic [WordBits-1:0] r_next [DivStages];
    logic [WordBits-1:0] d_next [DivStages];

    always_comb begin
        logic [WordBits-1:0] qi, ri, di;
        logic [WordBits:0]   t;
        logic [WordBits:0]   diff;
        for (int i = 0; i < DivStages; i++) begin
            qi = (i == 0) ? dvd : q_reg[(i == 0) ? 0 : i - 1];
            ri = (i == 0) ? '0  : r_reg[(i == 0) ? 0 : i - 1];
            di = (i == 0) ? dsr : d_reg[(i == 0) ? 0 : i - 1];
            t    = {ri, qi[WordBits-1]};
            diff = t - {1'b0, di};
            d_next[i] = di;
            if (!diff[WordBits]) begin
                r_next[i] = diff[WordBits-1:0];
                q_next[i] = {qi[WordBits-2:0], 1'b1};
            end else begin
                r_next[i] = t[WordBits-1:0];
                q_next[i] = {qi[WordBits-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < DivStages; i++) begin
                q_reg[i] <= q_next[i];
                r_reg[i] <= r_next[i];
                d_reg[i] <= d_next[i];
            end
        end
    end

    assign quot = q_reg[DivStages-1];
    assign rem  = r_reg[DivStages-1];

endmodule

### src/pca_alu.sv
module pca_alu
    import pca_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  dec_t dec,
    output alu_t alu
);

    localparam int DelayStages = DivStages - 1;

    logic [63:0] p0_reg, p1_reg, p2_reg, p0_next, p1_next, p2_next;
    logic [63:0] v_reg, v_next;
    meta_t       m1_reg;
    alu_t        s2_next;
    alu_t        dly_reg [DelayStages];
    logic [5:0]  sh;
    logic [2:0]  bytes;

    always_comb begin
        sh      = dec.b[5:0] & 6'(ShiftMask);
        bytes   = dec.b[2:0];
        p0_next = dec.a[31:0] * dec.b[31:0];
        p1_next = dec.a[31:0] * dec.b[63:32];
        p2_next = dec.a[63:32] * dec.b[31:0];
        case (dec.meta.kind)
            OP_COPY, OP_ZEXT: v_next = dec.a;
            OP_ADD:   v_next = dec.a + dec.b;
            OP_SUB:   v_next = dec.a - dec.b;
            OP_AND:   v_next = dec.a & dec.b;
            OP_OR:    v_next = dec.a | dec.b;
            OP_XOR:   v_next = dec.a ^ dec.b;
            OP_SHL:   v_next = dec.a << sh;
            OP_SHR:   v_next = dec.a >> sh;
            OP_SAR:   v_next = 64'($signed(dec.xa) >>> sh);
            OP_NEG:   v_next = ~dec.a + 64'd1;
            OP_NOT:   v_next = ~dec.a;
            OP_EQ:    v_next = {63'd0, dec.a == dec.b};
            OP_NE:    v_next = {63'd0, dec.a != dec.b};
            OP_LT:    v_next = {63'd0, dec.a < dec.b};
            OP_LE:    v_next = {63'd0, dec.a <= dec.b};
            OP_SLT:   v_next = {63'd0, $signed(dec.xa) < $signed(dec.xb)};
            OP_SLE:   v_next = {63'd0, $signed(dec.xa) <= $signed(dec.xb)};
            OP_SEXT:  v_next = dec.xa;
            OP_SUBPIECE: v_next = (dec.b >= 64'(WordBytes)) ? '0
                                  : (dec.a >> {bytes, 3'b000});
            default:  v_next = '0;
        endcase
    end

    always_comb begin
        s2_next.meta = m1_reg;
        if (m1_reg.kind == OP_MUL) begin
            s2_next.res = p0_reg + {p1_reg[31:0] + p2_reg[31:0], 32'd0};
        end else begin
            s2_next.res = v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_reg.valid <= 1'b0;
            for (int i = 0; i < DelayStages; i++) begin
                dly_reg[i].meta.valid <= 1'b0;
            end
        end else if (en) begin
            m1_reg     <= dec.meta;
            dly_reg[0] <= s2_next;
            for (int i = 1; i < DelayStages; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            v_reg  <= v_next;
        end
    end

    assign alu = dly_reg[DelayStages-1];

endmodule

### test/pcode_integer_alu_test.sv
module pcode_integer_alu_test;
    import pca_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [4:0]  kind;
        logic [63:0] a;
        logic [3:0]  sa;
        logic [63:0] b;
        logic [3:0]  sb;
        logic [3:0]  rs;
    } op_item_t;

    typedef struct {
        logic [63:0] value;
        logic [1:0]  fault;
    } alu_result_t;

    // Predicts each result of the ALU and checks the returned ones in order.
    class alu_scoreboard;
        alu_result_t pending[$];
        int errors;

        function logic [63:0] narrow(logic [63:0] v, logic [3:0] sz);
            if (sz == 0 || sz >= WordBytes) return v;
            return v & ((64'd1 << (sz * 8)) - 64'd1);
        endfunction

        function logic [63:0] widen_signed(logic [63:0] v, logic [3:0] sz);
            logic [63:0] n;
            n = narrow(v, sz);
            if (sz == 0 || sz >= WordBytes) return v;
            if (n[sz * 8 - 1]) n = n | ~((64'd1 << (sz * 8)) - 64'd1);
            return n;
        endfunction

        function alu_result_t compute(op_item_t it);
            alu_result_t r;
            logic [63:0] a, b, xa, xb, v, ma, mb;
            logic [5:0] sh;
            a = narrow(it.a, it.sa);
            b = narrow(it.b, it.sb);
            xa = widen_signed(a, it.sa);
            xb = widen_signed(b, it.sb);
            sh = b[5:0];
            ma = xa[63] ? -xa : xa;
            mb = xb[63] ? -xb : xb;
            v = '0;
            r.fault = FAULT_NONE;
            case (it.kind)
                OP_COPY, OP_ZEXT: v = a;
                OP_ADD: v = a + b;
                OP_SUB: v = a - b;
                OP_MUL: v = a * b;
                OP_DIV: if (b == 0) r.fault = FAULT_DIV_ZRO; else v = a / b;
                OP_SDIV: begin
                    if (xb == 0) begin
                        r.fault = FAULT_DIV_ZRO;
                    end else begin
                        v = ma / mb;
                        if (xa[63] != xb[63]) v = -v;
                    end
                end
                OP_REM: if (b == 0) r.fault = FAULT_REM_ZRO; else v = a % b;
                OP_SREM: begin
                    if (xb == 0) begin
                        r.fault = FAULT_REM_ZRO;
                    end else begin
                        v = ma % mb;
                        if (xa[63]) v = -v;
                    end
                end
                OP_AND: v = a & b;
                OP_OR: v = a | b;
                OP_XOR: v = a ^ b;
                OP_SHL: v = a << sh;
                OP_SHR: v = a >> sh;
                OP_SAR: v = $signed(xa) >>> sh;
                OP_NEG: v = -a;
                OP_NOT: v = ~a;
                OP_EQ: v = 64'(a == b);
                OP_NE: v = 64'(a != b);
                OP_LT: v = 64'(a < b);
                OP_LE: v = 64'(a <= b);
                OP_SLT: v = 64'($signed(xa) < $signed(xb));
                OP_SLE: v = 64'($signed(xa) <= $signed(xb));
                OP_SEXT: v = xa;
                OP_SUBPIECE: v = (b >= WordBytes) ? 64'd0 : (a >> (b * 8));
                default: v = '0;
            endcase
            r.value = narrow(v, it.rs);
            return r;
        endfunction

        function void note_input(op_item_t it);
            pending = {pending, compute(it)};
        endfunction

        function void check_result(logic [63:0] value, logic [1:0] fault);
            alu_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h fault %0d", $time, value, fault);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (value !== e.value) begin
                $display("%0t: result expected %h actual %h", $time, e.value, value);
                errors++;
            end
            if (fault !== e.fault) begin
                $display("%0t: fault expected %0d actual %0d", $time, e.fault, fault);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [151:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [71:0] m_tdata;

    alu_scoreboard board = new();
    bit calm = 1'b0;
    bit hold_output = 1'b0;
    int stuck_cycles = 0;

    pcode_integer_alu dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #1 aclk = ~aclk;

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            2: v = 64'h8000_0000_0000_0000 >> ($urandom_range(0, 7) * 8);
            3: v = 64'($urandom_range(0, 9));
            default: ;
        endcase
        return v;
    endfunction

    // Sends one transaction, holding it until the block takes it. Without an
    // idle gap tvalid stays high, so the next transaction follows back to back.
    task automatic send_op(op_item_t it);
        @(negedge aclk);
        s_tdata <= {7'd0, it.rs, it.sb, it.b, it.sa, it.a, it.kind};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        board.note_input(it);
        if (!calm && $urandom_range(0, 3) == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
    endtask

    task automatic stop_input();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic send_fields(int k, logic [63:0] a, int sa, logic [63:0] b, int sb, int rs);
        op_item_t it;
        it.kind = 5'(k); it.a = a; it.sa = 4'(sa); it.b = b; it.sb = 4'(sb);
        it.rs = 4'(rs);
        send_op(it);
    endtask

    // Receiver side: random stalls, or a long hold-off when requested.
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_output) begin
                m_tready <= 1'b0;
                repeat (200) @(negedge aclk);
                hold_output = 1'b0;
                m_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata[63:0], m_tdata[65:64]);
        if (aresetn && !((m_tvalid && m_tready) || (s_tvalid && s_tready)))
            stuck_cycles <= stuck_cycles + 1;
        else
            stuck_cycles <= 0;
        if (stuck_cycles > 5000) begin
            $display("pcode_integer_alu verification failed");
            $finish;
        end
    end

    initial begin
        op_item_t it;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: every kind, size extremes, zero divisors, signed corners.
        for (int k = 0; k < 25; k++)
            send_fields(k, 64'h8000_0000_0000_0080, 8, 64'hffff_ffff_ffff_ffff, 8, 8);
        send_fields(OP_DIV, 64'd5, 1, 64'h100, 1, 8);
        send_fields(OP_SREM, 64'd5, 1, 64'h0, 8, 8);
        send_fields(OP_SDIV, 64'h80, 1, 64'hff, 1, 1);
        send_fields(OP_SREM, 64'h8000_0000_0000_0000, 8, '1, 8, 8);
        send_fields(OP_SUBPIECE, '1, 8, 64'd8, 1, 8);
        send_fields(OP_SEXT, 64'h80, 0, 64'd0, 15, 0);
        send_fields(OP_SAR, 64'h80, 1, 64'd127, 1, 8);
        send_fields(31, '1, 8, '1, 8, 8);

        // The block must fill and stall its input while the output is held.
        hold_output = 1'b1;
        for (int i = 0; i < 150; i++) begin
            it.kind = 5'($urandom_range(0, 24)); it.a = rand64(); it.b = rand64();
            it.sa = 4'($urandom_range(1, 8)); it.sb = 4'($urandom_range(1, 8));
            it.rs = 4'($urandom_range(1, 8));
            send_op(it);
        end
        stop_input();
        // Drain fully before continuing.
        while (board.pending.size() != 0) @(negedge aclk);

        for (int i = 0; i < 1000; i++) begin
            if (i == 850) calm = 1'b1;
            it.kind = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                  : 5'($urandom_range(0, 24));
            it.a = rand64(); it.b = rand64();
            if ($urandom_range(0, 9) == 0) begin
                it.sa = 4'($urandom()); it.sb = 4'($urandom()); it.rs = 4'($urandom());
            end else begin
                it.sa = 4'($urandom_range(1, 8)); it.sb = 4'($urandom_range(1, 8));
                it.rs = 4'($urandom_range(1, 8));
            end
            if (it.kind == OP_SUBPIECE && $urandom_range(0, 1))
                it.b = 64'($urandom_range(0, 9));
            send_op(it);
        end
        stop_input();

        while (board.pending.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (board.errors == 0)
            $display("pcode_integer_alu verification clean");
        else
            $display("pcode_integer_alu verification failed");
        $finish;
    end
endmodule

### files.f
src/pca_pkg.sv
src/pca_decode.sv
src/pca_div.sv
src/pca_alu.sv
src/pcode_integer_alu.sv
test/pcode_integer_alu_test.sv
